[design/assert_macros.svh]
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, c)
`define ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

[design/snt_pkg.sv]
package snt_pkg;
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIGIT,
        OP_DIV_START,
        OP_DIV_STEP,
        OP_FACTOR,
        OP_NEXT_D,
        OP_REST
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   digit_of_n;
    } dp_cmd_t;

    typedef struct packed {
        logic n_small;
        logic digits_done;
        logic div_done;
        logic rem_zero;
        logic sq_gt;
        logic rest_gt1;
        logic composite;
    } dp_status_t;

    localparam int unsigned OWN_W  = 7;
    localparam int unsigned FSUM_W = 8;
endpackage

[design/snt_datapath.sv]
`include "assert_macros.svh"
module snt_datapath #(
    parameter int unsigned NUM_BITS = 31
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [30:0]                 number,
    input  snt_pkg::dp_cmd_t            cmd,
    output snt_pkg::dp_status_t         status,
    output logic [snt_pkg::OWN_W-1:0]   own_sum,
    output logic [snt_pkg::FSUM_W-1:0]  fsum
);
    import snt_pkg::*;

    localparam int unsigned CW = $clog2(NUM_BITS + 1);

    logic [NUM_BITS-1:0] rest_reg, d_reg, dig_reg;
    logic [NUM_BITS-1:0] quo_reg, rem_reg;
    logic [NUM_BITS-1:0] dvd_reg, dvs_reg;
    logic [CW-1:0]       cnt_reg;
    logic [OWN_W-1:0]    own_reg;
    logic [FSUM_W+1:0]   fsum_reg;
    logic                comp_reg;
    logic                n_small_reg;

    logic [NUM_BITS:0]   rem_shift;
    logic [NUM_BITS:0]   rem_diff;
    logic [2*NUM_BITS-1:0] d_sq;
    logic [NUM_BITS+31:0]  q_prod;
    logic [NUM_BITS-1:0]   q10;
    logic [3:0]            r10;

    // Restoring division, one quotient bit per cycle.
    assign rem_shift = {rem_reg, dvd_reg[NUM_BITS-1]};
    assign rem_diff  = rem_shift - {1'b0, dvs_reg};
    assign d_sq      = d_reg * d_reg;

    // Divide by ten through the reciprocal; the remainder fits in four bits.
    assign q_prod = dig_reg * 32'hCCCC_CCCD;
    assign q10    = {3'b000, q_prod[NUM_BITS+31:35]};
    assign r10    = dig_reg[3:0] - {q10[0], 3'b000} - {q10[2:0], 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rest_reg    <= '0;
            d_reg       <= '0;
            dig_reg     <= '0;
            quo_reg     <= '0;
            rem_reg     <= '0;
            dvd_reg     <= '0;
            dvs_reg     <= '0;
            cnt_reg     <= '0;
            own_reg     <= '0;
            fsum_reg    <= '0;
            comp_reg    <= 1'b0;
            n_small_reg <= 1'b0;
        end
        else
        begin
            case (cmd.op)
                OP_LOAD:
                begin
                    rest_reg    <= number[NUM_BITS-1:0];
                    dig_reg     <= number[NUM_BITS-1:0];
                    n_small_reg <= (number[NUM_BITS-1:0] < NUM_BITS'(2));
                    d_reg       <= NUM_BITS'(2);
                    own_reg     <= '0;
                    fsum_reg    <= '0;
                    comp_reg    <= 1'b0;
                end
                OP_DIV_START:
                begin
                    // trial division of the cofactor by d
                    dvd_reg <= rest_reg;
                    dvs_reg <= d_reg;
                    rem_reg <= '0;
                    quo_reg <= '0;
                    cnt_reg <= CW'(NUM_BITS);
                end
                OP_DIV_STEP:
                begin
                    dvd_reg <= dvd_reg << 1;
                    cnt_reg <= cnt_reg - CW'(1);
                    if (!rem_diff[NUM_BITS])
                    begin
                        rem_reg <= rem_diff[NUM_BITS-1:0];
                        quo_reg <= {quo_reg[NUM_BITS-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_shift[NUM_BITS-1:0];
                        quo_reg <= {quo_reg[NUM_BITS-2:0], 1'b0};
                    end
                end
                OP_DIGIT:
                begin
                    // strip the low decimal digit and accumulate it
                    dig_reg <= q10;
                    if (cmd.digit_of_n)
                        own_reg <= own_reg + OWN_W'(r10);
                    else if (fsum_reg < (FSUM_W+2)'(512))
                        fsum_reg <= fsum_reg + (FSUM_W+2)'(r10);
                end
                OP_FACTOR:
                begin
                    comp_reg <= 1'b1;
                    rest_reg <= quo_reg;
                    dig_reg  <= d_reg;
                end
                OP_NEXT_D:
                    d_reg <= d_reg + NUM_BITS'(1);
                OP_REST:
                    dig_reg <= rest_reg;
                default:
                begin
                end
            endcase
        end
    end

    assign status.n_small     = n_small_reg;
    assign status.digits_done = (dig_reg == '0);
    assign status.div_done    = (cnt_reg == '0);
    assign status.rem_zero    = (rem_reg == '0);
    assign status.sq_gt       = (d_sq > {{NUM_BITS{1'b0}}, rest_reg});
    assign status.rest_gt1    = (rest_reg > NUM_BITS'(1));
    assign status.composite   = comp_reg;
    assign own_sum            = own_reg;
    assign fsum = (fsum_reg > (FSUM_W+2)'(255)) ? FSUM_W'(255) : fsum_reg[FSUM_W-1:0];

    `ASSERT_NEXT(a_div_count, clk, rst_n, cmd.op == OP_DIV_START, cnt_reg == CW'(NUM_BITS))
    `ASSERT_NEXT(a_factor_comp, clk, rst_n, cmd.op == OP_FACTOR, comp_reg)
    `ASSERT_IMPLIES(a_d_min, clk, rst_n, cmd.op == OP_NEXT_D, d_reg >= NUM_BITS'(2))
endmodule

[design/snt_ctrl.sv]
`include "assert_macros.svh"
module snt_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  snt_pkg::dp_status_t status,
    output snt_pkg::dp_cmd_t    cmd,
    output logic                busy,
    output logic                done
);
    import snt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_OWN_DIGIT, S_CHECK, S_FAC_STEP, S_FAC_TEST, S_FD_DIGIT, S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   rest_phase_reg, rest_phase_next;

    always_comb
    begin
        state_next      = state_reg;
        rest_phase_next = rest_phase_reg;
        cmd.op          = OP_NONE;
        cmd.digit_of_n  = 1'b0;
        case (state_reg)
            S_IDLE:
                if (start)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_OWN_DIGIT;
                end
            S_OWN_DIGIT:
                if (status.digits_done)
                    state_next = status.n_small ? S_DONE : S_CHECK;
                else
                begin
                    cmd.op = OP_DIGIT; cmd.digit_of_n = 1'b1;
                end
            S_CHECK:
                if (status.sq_gt)
                begin
                    if (status.composite && status.rest_gt1)
                    begin
                        cmd.op = OP_REST; rest_phase_next = 1'b1;
                        state_next = S_FD_DIGIT;
                    end
                    else
                        state_next = S_DONE;
                end
                else
                begin
                    cmd.op = OP_DIV_START;
                    state_next = S_FAC_STEP;
                end
            S_FAC_STEP:
                if (status.div_done)
                    state_next = S_FAC_TEST;
                else
                    cmd.op = OP_DIV_STEP;
            S_FAC_TEST:
                if (status.rem_zero)
                begin
                    cmd.op = OP_FACTOR; rest_phase_next = 1'b0;
                    state_next = S_FD_DIGIT;
                end
                else
                begin
                    cmd.op = OP_NEXT_D;
                    state_next = S_CHECK;
                end
            S_FD_DIGIT:
                if (status.digits_done)
                    state_next = rest_phase_reg ? S_DONE : S_CHECK;
                else
                    cmd.op = OP_DIGIT;
            S_DONE:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            rest_phase_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rest_phase_reg <= rest_phase_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

    `ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
    `ASSERT_NEXT(a_done_idle, clk, rst_n, done, !busy)
    `ASSERT_IMPLIES(a_done_busy, clk, rst_n, done, busy)
endmodule

[design/smith_number_test_core.sv]
// Channel   Handshake                Payload
// input     start, taken when !busy  number
// result    done, one-cycle strobe   is_smith, own_digit_sum, factor_digit_sum
//
// Own digit sum: strips one decimal digit per step, then checks for zero. Each trial
// divisor runs start, NUM_BITS quotient bits, done check and test on the
// shared bit-serial divider; each factor found adds a digit-sum pass over its digits.
// Large primes near two to the 31 need about 46341 trial divisors.
// rst_n returns the controller to idle asynchronously and drops any item in flight.
// The receiver cannot stall: the result is valid only while done is high.
module smith_number_test_core #(
    parameter int unsigned NUM_BITS = 31
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [30:0] number,
    output logic        done,
    output logic        is_smith,
    output logic [6:0]  own_digit_sum,
    output logic [7:0]  factor_digit_sum
);
    import snt_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    logic [OWN_W-1:0]  own_sum;
    logic [FSUM_W-1:0] fsum;

    // Sequence digit sums and trial division.
    snt_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // Hold cofactor, divisor and sums; run the shared divider.
    snt_datapath #(.NUM_BITS(NUM_BITS)) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .number  (number),
        .cmd     (cmd),
        .status  (status),
        .own_sum (own_sum),
        .fsum    (fsum)
    );

    assign own_digit_sum    = own_sum;
    assign factor_digit_sum = status.composite ? fsum : 8'd0;
    assign is_smith = status.composite && ({1'b0, own_sum} == fsum);
endmodule
